// ===== hw/rtl/ipsa_pkg.sv =====
// Package with the shared types, codes and constants of the interrupt-pacing slot allocator.
`timescale 1ns / 1ps

package ipsa_pkg;

    // Number of pacing slots by default.
    localparam int SLOT_COUNT = 4;

    // Widths of the fixed fields.
    localparam int LINE_W = 6;
    localparam int IRQ_W = 8;
    localparam int HANDLE_W = 3;
    localparam int HOUT_W = 2;
    localparam int MASK_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // Reset values of the configuration registers.
    localparam logic [IRQ_W-1:0] LINE_BASE_RST = 8'd8;
    localparam logic [IRQ_W-1:0] LINE_END_RST = 8'd48;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_UNREGISTER = 2'd1,
        OP_SET_MAX    = 2'd2,
        OP_NONE       = 2'd3
    } t_op;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_DUP   = 3'd1,
        ST_FULL  = 3'd2,
        ST_RANGE = 3'd3,
        ST_BADH  = 3'd4
    } t_status;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_BASE = 2'd0,
        CFG_LINE_END  = 2'd1
    } t_cfg_idx;

    // Input item.
    typedef struct packed {
        logic [1:0]          op;
        logic [IRQ_W-1:0]    irq_number;
        logic [HANDLE_W-1:0] handle;
        logic [7:0]          max_count;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [2:0]        status;
        logic [HOUT_W-1:0] handle_out;
        logic [MASK_W-1:0] enable_mask;
        logic [LINE_W-1:0] slot_line;
        logic [LINE_W-1:0] slot_max;
    } t_out_item;

    // Configuration write.
    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_item;

endpackage

// ===== hw/rtl/ipsa_stream_if.sv =====
// Valid/ready channel interface that carries one payload type.
`timescale 1ns / 1ps

interface ipsa_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/irq_pacing_slot_allocator_unit.sv =====
// Top level of the interrupt-pacing slot allocator.
`timescale 1ns / 1ps

// Channel   Dir  Payload                                          Handshake
// i_in      in   op, irq_number, handle, max_count                valid/ready
// o_out     out  status, handle_out, enable_mask, slot_line,      valid/ready
//                slot_max
// i_cfg     in   index, data (register 0 line_base, 1 line_end)   valid/ready
//
// An accepted item is held in the input register, is evaluated against the slot
// table in one pass and lands in the result register together with the table
// update; one item can be taken in every cycle unless the output stalls.
// The input register only stalls while the result register holds an item that is
// not taken. Reset clears the slot table and loads the default line range; the
// configuration channel is always ready.

module irq_pacing_slot_allocator_unit #(
    parameter int SLOT_COUNT = ipsa_pkg::SLOT_COUNT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ipsa_stream_if.sink   i_in,
    ipsa_stream_if.source o_out,
    ipsa_stream_if.sink   i_cfg
);

    localparam int LW = ipsa_pkg::LINE_W;

    // Configuration registers.
    logic [ipsa_pkg::IRQ_W-1:0] r_line_base;
    logic [ipsa_pkg::IRQ_W-1:0] r_line_end;

    // Slot table.
    logic [SLOT_COUNT-1:0] r_used, n_used;
    logic [SLOT_COUNT-1:0] r_en, n_en;
    logic [LW-1:0]         r_owner [SLOT_COUNT];
    logic [LW-1:0]         n_owner [SLOT_COUNT];
    logic [LW-1:0]         r_map [SLOT_COUNT];
    logic [LW-1:0]         n_map [SLOT_COUNT];
    logic [LW-1:0]         r_max [SLOT_COUNT];
    logic [LW-1:0]         n_max [SLOT_COUNT];

    // Input and result registers.
    logic                 r_s1_valid;
    ipsa_pkg::t_in_item   r_s1;
    logic                 r_out_valid;
    ipsa_pkg::t_out_item  r_out;
    ipsa_pkg::t_out_item  n_out;

    logic s1_advance;
    logic in_xfer;

    // Evaluation signals.
    logic                  in_range;
    logic [LW-1:0]         new_line;
    logic                  dup;
    logic                  found;
    logic [SLOT_COUNT-1:0] free_sel;
    logic [SLOT_COUNT-1:0] hnd_sel;
    logic                  hnd_ok;
    logic [LW-1:0]         eff_max;
    logic [SLOT_COUNT-1:0] sel;
    logic                  have_slot;
    logic [2:0]            status;
    logic [ipsa_pkg::HOUT_W-1:0] slot_idx;
    logic [LW-1:0]         rd_map;
    logic [LW-1:0]         rd_max;
    logic [ipsa_pkg::MASK_W-1:0] mask;

    // Handshake control.
    assign s1_advance  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || s1_advance;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out;

    // Register-op checks: range, duplicate line, highest free slot.
    always_comb begin
        in_range = (r_s1.irq_number >= r_line_base) && (r_s1.irq_number < r_line_end);
        new_line = LW'(r_s1.irq_number - r_line_base);
        dup      = 1'b0;
        found    = 1'b0;
        free_sel = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (r_used[i] && (r_owner[i] == new_line)) begin
                dup = 1'b1;
            end
            if (!r_used[i]) begin
                found    = 1'b1;
                free_sel = '0;
                free_sel[i] = 1'b1;
            end
        end
    end

    // Handle decode for unregister and set.
    always_comb begin
        hnd_sel = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            hnd_sel[i] = (int'(r_s1.handle) == i) && r_used[i];
        end
        hnd_ok  = |hnd_sel;
        eff_max = r_s1.max_count[LW-1:0];
        if (eff_max == LW'(1)) begin
            eff_max = '0;
        end
    end

    // Operation decode: status and the slot the result refers to.
    always_comb begin
        status    = ipsa_pkg::ST_BADH;
        sel       = '0;
        have_slot = 1'b0;
        case (ipsa_pkg::t_op'(r_s1.op))
            ipsa_pkg::OP_REGISTER: begin
                if (!in_range) begin
                    status = ipsa_pkg::ST_RANGE;
                end else if (dup) begin
                    status = ipsa_pkg::ST_DUP;
                end else if (!found) begin
                    status = ipsa_pkg::ST_FULL;
                end else begin
                    status    = ipsa_pkg::ST_OK;
                    sel       = free_sel;
                    have_slot = 1'b1;
                end
            end
            ipsa_pkg::OP_UNREGISTER, ipsa_pkg::OP_SET_MAX: begin
                if (hnd_ok) begin
                    status    = ipsa_pkg::ST_OK;
                    sel       = hnd_sel;
                    have_slot = 1'b1;
                end
            end
            default: begin
                status = ipsa_pkg::ST_BADH;
            end
        endcase
    end

    // Next slot table.
    always_comb begin
        n_used = r_used;
        n_en   = r_en;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            n_owner[i] = r_owner[i];
            n_map[i]   = r_map[i];
            n_max[i]   = r_max[i];
            if (sel[i]) begin
                case (ipsa_pkg::t_op'(r_s1.op))
                    ipsa_pkg::OP_REGISTER: begin
                        n_used[i]  = 1'b1;
                        n_owner[i] = new_line;
                        n_en[i]    = 1'b0;
                    end
                    ipsa_pkg::OP_UNREGISTER: begin
                        n_used[i] = 1'b0;
                        n_en[i]   = 1'b0;
                    end
                    ipsa_pkg::OP_SET_MAX: begin
                        if (eff_max == '0) begin
                            n_en[i] = 1'b0;
                        end else begin
                            n_map[i] = r_owner[i];
                            n_max[i] = eff_max;
                            n_en[i]  = 1'b1;
                        end
                    end
                    default: begin
                        n_used[i] = r_used[i];
                    end
                endcase
            end
        end
    end

    // Read back the selected slot after the update.
    always_comb begin
        slot_idx = '0;
        rd_map   = '0;
        rd_max   = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (sel[i]) begin
                slot_idx = ipsa_pkg::HOUT_W'(i);
                rd_map   = rd_map | n_map[i];
                rd_max   = rd_max | n_max[i];
            end
        end
    end

    // Enable mask covers the first four slots.
    for (genvar gi = 0; gi < ipsa_pkg::MASK_W; gi++) begin : g_mask
        if (gi < SLOT_COUNT) begin : g_on
            assign mask[gi] = n_en[gi];
        end else begin : g_off
            assign mask[gi] = 1'b0;
        end
    end

    // Result item.
    always_comb begin
        n_out.status      = status;
        n_out.handle_out  = have_slot ? slot_idx : '0;
        n_out.enable_mask = mask;
        n_out.slot_line   = rd_map;
        n_out.slot_max    = rd_max;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_base <= ipsa_pkg::LINE_BASE_RST;
            r_line_end  <= ipsa_pkg::LINE_END_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (ipsa_pkg::t_cfg_idx'(i_cfg.payload.index))
                ipsa_pkg::CFG_LINE_BASE: r_line_base <= i_cfg.payload.data;
                ipsa_pkg::CFG_LINE_END:  r_line_end  <= i_cfg.payload.data;
                default: begin
                    r_line_base <= r_line_base;
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1 <= i_in.payload;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out <= n_out;
        end
    end

    // Slot table update when an item is evaluated.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_en   <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_owner[i] <= '0;
                r_map[i]   <= '0;
                r_max[i]   <= '0;
            end
        end else if (s1_advance) begin
            r_used <= n_used;
            r_en   <= n_en;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_owner[i] <= n_owner[i];
                r_map[i]   <= n_map[i];
                r_max[i]   <= n_max[i];
            end
        end
    end

    // Pacing is only ever enabled on a slot that is in use.
    a_en_needs_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_en & ~r_used) == '0)
        else $error("pacing enabled on a free slot");

    // A failed step reports no slot data.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != ipsa_pkg::ST_OK)) |->
        (r_out.handle_out == '0 && r_out.slot_line == '0 && r_out.slot_max == '0))
        else $error("failed result carries slot data");

    // An empty result register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with an empty result register");

    // An evaluated item always shows up in the result register.
    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_advance |=> r_out_valid)
        else $error("evaluated item lost");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the interrupt-pacing slot allocator, with a table predictor.
`timescale 1ns / 1ps

module tb_top;

    // After the item transfer, the result passes the input register and then the result register.
    localparam int LATENCY = 2;
    localparam int SETTLE_CYCLES = 2 * LATENCY;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int MAX_HOLD = 12;
    localparam int PHASE_ITEMS = 290;
    localparam int SLOTS = ipsa_pkg::SLOT_COUNT;

    // One entry of the stimulus queue: an operation or a register write.
    typedef struct {
        bit                  is_cfg;
        ipsa_pkg::t_in_item  req;
        ipsa_pkg::t_cfg_item wr;
    } t_pending;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ipsa_stream_if #(.T(ipsa_pkg::t_in_item))  in_if ();
    ipsa_stream_if #(.T(ipsa_pkg::t_out_item)) out_if ();
    ipsa_stream_if #(.T(ipsa_pkg::t_cfg_item)) cfg_if ();

    // Testbench-side drivers, known from time zero.
    logic                req_valid = 1'b0;
    ipsa_pkg::t_in_item  req_data = '0;
    logic                wr_valid = 1'b0;
    ipsa_pkg::t_cfg_item wr_data = '0;
    logic                res_ready = 1'b0;

    assign in_if.valid    = req_valid;
    assign in_if.payload  = req_data;
    assign cfg_if.valid   = wr_valid;
    assign cfg_if.payload = wr_data;
    assign out_if.ready   = res_ready;

    irq_pacing_slot_allocator_unit #(
        .SLOT_COUNT(SLOTS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predicted configuration and slot table.
    logic [7:0] line_base_q = ipsa_pkg::LINE_BASE_RST;
    logic [7:0] line_end_q = ipsa_pkg::LINE_END_RST;
    logic       claimed [SLOTS] = '{default: 1'b0};
    logic [5:0] owner_line [SLOTS] = '{default: '0};
    logic [5:0] mapped_line [SLOTS] = '{default: '0};
    logic [5:0] pace_limit [SLOTS] = '{default: '0};
    logic       pace_on [SLOTS] = '{default: 1'b0};

    t_pending            pending_q[$];
    ipsa_pkg::t_out_item expected_q[$];
    int        n_sent = 0;
    int        n_seen = 0;
    int        errors = 0;
    int        cycle_count = 0;

    // Apply one operation to the predicted table and return the result it gives.
    function automatic ipsa_pkg::t_out_item slot_table_outcome(ipsa_pkg::t_in_item req);
        ipsa_pkg::t_out_item res;
        logic [7:0] offset;
        logic [5:0] line;
        logic [5:0] limit;
        bit         dup;
        bit         found;
        bit         granted;
        int         slot;
        int         h;
        res = '0;
        res.status = ipsa_pkg::ST_BADH;
        dup = 1'b0;
        found = 1'b0;
        granted = 1'b0;
        slot = 0;
        h = 32'(req.handle);
        offset = req.irq_number - line_base_q;
        line = offset[5:0];
        limit = req.max_count[5:0];
        case (ipsa_pkg::t_op'(req.op))
            ipsa_pkg::OP_REGISTER: begin
                if (req.irq_number < line_base_q || req.irq_number >= line_end_q) begin
                    res.status = ipsa_pkg::ST_RANGE;
                end else begin
                    // The highest free slot wins; any holder of the same line blocks.
                    for (int s = 0; s < SLOTS; s++) begin
                        if (claimed[s] && owner_line[s] == line) dup = 1'b1;
                        if (!claimed[s]) begin
                            slot = s;
                            found = 1'b1;
                        end
                    end
                    if (dup) begin
                        res.status = ipsa_pkg::ST_DUP;
                    end else if (!found) begin
                        res.status = ipsa_pkg::ST_FULL;
                    end else begin
                        claimed[slot] = 1'b1;
                        owner_line[slot] = line;
                        pace_on[slot] = 1'b0;
                        res.status = ipsa_pkg::ST_OK;
                        granted = 1'b1;
                    end
                end
            end
            ipsa_pkg::OP_UNREGISTER, ipsa_pkg::OP_SET_MAX: begin
                if (h < SLOTS) begin
                    if (claimed[h]) begin
                        slot = h;
                        granted = 1'b1;
                        res.status = ipsa_pkg::ST_OK;
                        if (ipsa_pkg::t_op'(req.op) == ipsa_pkg::OP_UNREGISTER) begin
                            pace_on[slot] = 1'b0;
                            claimed[slot] = 1'b0;
                        end else begin
                            // A max of one is treated as zero, which only disables pacing.
                            if (limit == 6'd1) limit = 6'd0;
                            if (limit == 6'd0) begin
                                pace_on[slot] = 1'b0;
                            end else begin
                                mapped_line[slot] = owner_line[slot];
                                pace_limit[slot] = limit;
                                pace_on[slot] = 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        for (int s = 0; s < SLOTS && s < ipsa_pkg::MASK_W; s++) begin
            res.enable_mask[s] = pace_on[s];
        end
        if (granted) begin
            res.handle_out = slot[ipsa_pkg::HOUT_W-1:0];
            res.slot_line = mapped_line[slot];
            res.slot_max = pace_limit[slot];
        end
        return res;
    endfunction

    // Cycles to hold off before the next transfer; none during a burst.
    function automatic int hold_cycles(bit burst);
        return burst ? 0 : $urandom_range(0, MAX_HOLD);
    endfunction

    task automatic flag_error(string what);
        errors++;
        if (errors <= MAX_REPORTS) $display("%s", what);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            flag_error($sformatf("result %0d: %s expected %0d, got %0d",
                                 n_seen, name, want, got));
        end
    endtask

    // Operation driver; register writes wait until the block has drained.
    int req_gap = 0;
    int settle = SETTLE_CYCLES;
    bit req_burst = 1'b0;

    always @(posedge i_clk) begin : request_driver
        logic                nxt_valid;
        ipsa_pkg::t_in_item  nxt_data;
        logic                nxt_wr_valid;
        ipsa_pkg::t_cfg_item nxt_wr_data;
        t_pending            head;
        int                  sent_now;
        nxt_valid = req_valid;
        nxt_data = req_data;
        nxt_wr_valid = wr_valid;
        nxt_wr_data = wr_data;
        sent_now = n_sent;
        if (i_rst_n) begin
            if (req_valid && in_if.ready) begin
                expected_q.push_back(slot_table_outcome(req_data));
                sent_now = n_sent + 1;
                n_sent <= sent_now;
                nxt_valid = 1'b0;
                if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
                req_gap = hold_cycles(req_burst);
            end
            if (wr_valid && cfg_if.ready) begin
                case (ipsa_pkg::t_cfg_idx'(wr_data.index))
                    ipsa_pkg::CFG_LINE_BASE: line_base_q = wr_data.data;
                    ipsa_pkg::CFG_LINE_END:  line_end_q = wr_data.data;
                    default: begin
                    end
                endcase
                nxt_wr_valid = 1'b0;
                settle = SETTLE_CYCLES;
            end
            if (!nxt_valid && !nxt_wr_valid && pending_q.size() > 0) begin
                if (pending_q[0].is_cfg) begin
                    if (sent_now != n_seen || out_if.valid) begin
                        settle = SETTLE_CYCLES;
                    end else if (settle > 0) begin
                        settle--;
                    end else begin
                        head = pending_q.pop_front();
                        nxt_wr_valid = 1'b1;
                        nxt_wr_data = head.wr;
                    end
                end else if (req_gap > 0) begin
                    req_gap--;
                end else begin
                    head = pending_q.pop_front();
                    nxt_valid = 1'b1;
                    nxt_data = head.req;
                end
            end
        end
        req_valid <= nxt_valid;
        req_data <= nxt_data;
        wr_valid <= nxt_wr_valid;
        wr_data <= nxt_wr_data;
    end

    // Result monitor with random back-pressure.
    int res_wait = 0;
    bit res_burst = 1'b0;

    always @(posedge i_clk) begin : result_monitor
        logic                nxt_ready;
        ipsa_pkg::t_out_item want;
        ipsa_pkg::t_out_item got;
        nxt_ready = res_ready;
        if (i_rst_n) begin
            if (out_if.valid && res_ready) begin
                got = out_if.payload;
                if (n_seen < n_sent) begin
                    want = expected_q.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("handle_out", 32'(want.handle_out), 32'(got.handle_out));
                    check_field("enable_mask", 32'(want.enable_mask),
                                32'(got.enable_mask));
                    check_field("slot_line", 32'(want.slot_line), 32'(got.slot_line));
                    check_field("slot_max", 32'(want.slot_max), 32'(got.slot_max));
                    n_seen <= n_seen + 1;
                end else begin
                    flag_error($sformatf("unexpected result, status %0d", got.status));
                end
                if ($urandom_range(0, 39) == 0) res_burst = !res_burst;
                res_wait = hold_cycles(res_burst);
                nxt_ready = (res_wait == 0);
            end else if (!res_ready) begin
                if (res_wait > 0) res_wait--;
                if (res_wait == 0) nxt_ready = 1'b1;
            end
        end
        res_ready <= nxt_ready;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic queue_op(ipsa_pkg::t_op op, int irq, int handle, int maxc);
        t_pending p;
        p.is_cfg = 1'b0;
        p.wr = '0;
        p.req.op = op;
        p.req.irq_number = 8'(irq);
        p.req.handle = 3'(handle);
        p.req.max_count = 8'(maxc);
        pending_q.push_back(p);
    endtask

    task automatic queue_cfg(ipsa_pkg::t_cfg_idx idx, int value);
        t_pending p;
        p.is_cfg = 1'b1;
        p.req = '0;
        p.wr.index = idx;
        p.wr.data = 8'(value);
        pending_q.push_back(p);
    endtask

    // Random operations, mostly aimed at the configured line range and live handles.
    task automatic queue_random_phase(int lo, int hi, int count);
        int pick;
        int irq;
        int handle;
        int maxc;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            irq = $urandom_range(0, 255);
            handle = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
                                                   : $urandom_range(4, 7);
            maxc = $urandom_range(0, 255);
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: maxc = 0;
                    1: maxc = 1;
                    2: maxc = 64;
                    default: maxc = 65;
                endcase
            end
            if (pick < 35) begin
                if (hi > lo && $urandom_range(0, 9) < 8) irq = $urandom_range(lo, hi - 1);
                queue_op(ipsa_pkg::OP_REGISTER, irq, handle, maxc);
            end else if (pick < 57) begin
                queue_op(ipsa_pkg::OP_UNREGISTER, irq, handle, maxc);
            end else if (pick < 95) begin
                queue_op(ipsa_pkg::OP_SET_MAX, irq, handle, maxc);
            end else begin
                queue_op(ipsa_pkg::OP_NONE, irq, handle, maxc);
            end
        end
    endtask

    // Line ranges of the random phases, extremes and reversed ranges among them.
    int phase_lo [6] = '{0, 60, 255, 128, 0, 8};
    int phase_hi [6] = '{255, 66, 0, 255, 4, 48};

    initial begin
        // Directed part at the default line range 8..47.
        queue_op(ipsa_pkg::OP_REGISTER, 7, 0, 0);
        queue_op(ipsa_pkg::OP_REGISTER, 48, 0, 0);
        queue_op(ipsa_pkg::OP_REGISTER, 255, 7, 255);
        queue_op(ipsa_pkg::OP_REGISTER, 0, 0, 0);
        queue_op(ipsa_pkg::OP_SET_MAX, 0, 0, 5);
        queue_op(ipsa_pkg::OP_REGISTER, 8, 0, 0);
        queue_op(ipsa_pkg::OP_REGISTER, 47, 0, 0);
        queue_op(ipsa_pkg::OP_REGISTER, 8, 0, 0);
        queue_op(ipsa_pkg::OP_REGISTER, 20, 0, 0);
        queue_op(ipsa_pkg::OP_REGISTER, 30, 0, 0);
        queue_op(ipsa_pkg::OP_REGISTER, 40, 0, 0);
        queue_op(ipsa_pkg::OP_SET_MAX, 0, 3, 255);
        queue_op(ipsa_pkg::OP_SET_MAX, 0, 2, 1);
        queue_op(ipsa_pkg::OP_SET_MAX, 0, 1, 64);
        queue_op(ipsa_pkg::OP_SET_MAX, 0, 0, 2);
        queue_op(ipsa_pkg::OP_SET_MAX, 0, 4, 9);
        queue_op(ipsa_pkg::OP_SET_MAX, 255, 7, 255);
        queue_op(ipsa_pkg::OP_UNREGISTER, 0, 3, 0);
        queue_op(ipsa_pkg::OP_UNREGISTER, 0, 3, 0);
        queue_op(ipsa_pkg::OP_SET_MAX, 0, 3, 5);
        queue_op(ipsa_pkg::OP_NONE, 255, 7, 255);
        queue_op(ipsa_pkg::OP_REGISTER, 8, 0, 0);
        queue_op(ipsa_pkg::OP_SET_MAX, 0, 3, 0);
        queue_op(ipsa_pkg::OP_UNREGISTER, 0, 5, 0);

        // Random phases, each behind a fresh line range.
        for (int ph = 0; ph < 6; ph++) begin
            queue_cfg(ipsa_pkg::CFG_LINE_BASE, phase_lo[ph]);
            queue_cfg(ipsa_pkg::CFG_LINE_END, phase_hi[ph]);
            queue_random_phase(phase_lo[ph], phase_hi[ph], PHASE_ITEMS);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all stimulus sent and every expected result seen.
        @(posedge i_clk);
        while (pending_q.size() != 0 || req_valid || wr_valid || n_sent != n_seen) begin
            @(posedge i_clk);
        end
        repeat (4 * LATENCY) @(posedge i_clk);
        if (expected_q.size() != 0) flag_error("expected results left over");

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== irq_pacing_slot_allocator_unit.f =====
hw/rtl/ipsa_pkg.sv
hw/rtl/ipsa_stream_if.sv
hw/rtl/irq_pacing_slot_allocator_unit.sv
tb/sv/tb_top.sv
